>>> hw/rtl/kst_pkg.sv
// shared constants and layout tables for the keyboard scancode translator
package kst_pkg;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_SYNC = 1'b1;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    localparam logic [7:0] CMD_LED       = 8'hED;
    localparam logic [7:0] CODE_ACK      = 8'hFA;
    localparam logic [7:0] CODE_RESEND   = 8'hFE;
    localparam logic [7:0] CODE_LSHIFT   = 8'h2A;
    localparam logic [7:0] CODE_RSHIFT   = 8'h36;
    localparam logic [7:0] CODE_LSHIFT_R = 8'hAA;
    localparam logic [7:0] CODE_RSHIFT_R = 8'hB6;
    localparam logic [7:0] CODE_CAPS     = 8'h3A;
    localparam logic [7:0] CODE_NUM      = 8'h45;
    localparam logic [7:0] CODE_SCROLL   = 8'h46;

    localparam logic [2:0] LED_CAPS   = 3'b100;
    localparam logic [2:0] LED_NUM    = 3'b010;
    localparam logic [2:0] LED_SCROLL = 3'b001;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] value;
    } result_t;

    // unshifted layout
    function automatic logic [7:0] rom_plain(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'h02: ch = 8'h31;
            7'h03: ch = 8'h32;
            7'h04: ch = 8'h33;
            7'h05: ch = 8'h34;
            7'h06: ch = 8'h35;
            7'h07: ch = 8'h36;
            7'h08: ch = 8'h37;
            7'h09: ch = 8'h38;
            7'h0A: ch = 8'h39;
            7'h0B: ch = 8'h30;
            7'h0C: ch = 8'h2D;
            7'h0D: ch = 8'h5E;
            7'h0E: ch = 8'h08;
            7'h10: ch = 8'h51;
            7'h11: ch = 8'h57;
            7'h12: ch = 8'h45;
            7'h13: ch = 8'h52;
            7'h14: ch = 8'h54;
            7'h15: ch = 8'h59;
            7'h16: ch = 8'h55;
            7'h17: ch = 8'h49;
            7'h18: ch = 8'h4F;
            7'h19: ch = 8'h50;
            7'h1A: ch = 8'h40;
            7'h1B: ch = 8'h5B;
            7'h1C: ch = 8'h0A;
            7'h1E: ch = 8'h41;
            7'h1F: ch = 8'h53;
            7'h20: ch = 8'h44;
            7'h21: ch = 8'h46;
            7'h22: ch = 8'h47;
            7'h23: ch = 8'h48;
            7'h24: ch = 8'h4A;
            7'h25: ch = 8'h4B;
            7'h26: ch = 8'h4C;
            7'h27: ch = 8'h3B;
            7'h28: ch = 8'h3A;
            7'h2B: ch = 8'h5D;
            7'h2C: ch = 8'h5A;
            7'h2D: ch = 8'h58;
            7'h2E: ch = 8'h43;
            7'h2F: ch = 8'h56;
            7'h30: ch = 8'h42;
            7'h31: ch = 8'h4E;
            7'h32: ch = 8'h4D;
            7'h33: ch = 8'h2C;
            7'h34: ch = 8'h2E;
            7'h35: ch = 8'h2F;
            7'h37: ch = 8'h2A;
            7'h39: ch = 8'h20;
            7'h47: ch = 8'h37;
            7'h48: ch = 8'h38;
            7'h49: ch = 8'h39;
            7'h4A: ch = 8'h2D;
            7'h4B: ch = 8'h34;
            7'h4C: ch = 8'h35;
            7'h4D: ch = 8'h36;
            7'h4E: ch = 8'h2B;
            7'h4F: ch = 8'h31;
            7'h50: ch = 8'h32;
            7'h51: ch = 8'h33;
            7'h52: ch = 8'h30;
            7'h53: ch = 8'h2E;
            7'h73: ch = 8'h5C;
            7'h7D: ch = 8'h5C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // shifted layout
    function automatic logic [7:0] rom_shift(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'h02: ch = 8'h21;
            7'h03: ch = 8'h22;
            7'h04: ch = 8'h23;
            7'h05: ch = 8'h24;
            7'h06: ch = 8'h25;
            7'h07: ch = 8'h26;
            7'h08: ch = 8'h27;
            7'h09: ch = 8'h28;
            7'h0A: ch = 8'h29;
            7'h0B: ch = 8'h7E;
            7'h0C: ch = 8'h3D;
            7'h0D: ch = 8'h7E;
            7'h0E: ch = 8'h08;
            7'h10: ch = 8'h51;
            7'h11: ch = 8'h57;
            7'h12: ch = 8'h45;
            7'h13: ch = 8'h52;
            7'h14: ch = 8'h54;
            7'h15: ch = 8'h59;
            7'h16: ch = 8'h55;
            7'h17: ch = 8'h49;
            7'h18: ch = 8'h4F;
            7'h19: ch = 8'h50;
            7'h1A: ch = 8'h60;
            7'h1B: ch = 8'h7B;
            7'h1C: ch = 8'h0A;
            7'h1E: ch = 8'h41;
            7'h1F: ch = 8'h53;
            7'h20: ch = 8'h44;
            7'h21: ch = 8'h46;
            7'h22: ch = 8'h47;
            7'h23: ch = 8'h48;
            7'h24: ch = 8'h4A;
            7'h25: ch = 8'h4B;
            7'h26: ch = 8'h4C;
            7'h27: ch = 8'h2B;
            7'h28: ch = 8'h2A;
            7'h2B: ch = 8'h7D;
            7'h2C: ch = 8'h5A;
            7'h2D: ch = 8'h58;
            7'h2E: ch = 8'h43;
            7'h2F: ch = 8'h56;
            7'h30: ch = 8'h42;
            7'h31: ch = 8'h4E;
            7'h32: ch = 8'h4D;
            7'h33: ch = 8'h3C;
            7'h34: ch = 8'h3E;
            7'h35: ch = 8'h3F;
            7'h37: ch = 8'h2A;
            7'h39: ch = 8'h20;
            7'h47: ch = 8'h37;
            7'h48: ch = 8'h38;
            7'h49: ch = 8'h39;
            7'h4A: ch = 8'h2D;
            7'h4B: ch = 8'h34;
            7'h4C: ch = 8'h35;
            7'h4D: ch = 8'h36;
            7'h4E: ch = 8'h2B;
            7'h4F: ch = 8'h31;
            7'h50: ch = 8'h32;
            7'h51: ch = 8'h33;
            7'h52: ch = 8'h30;
            7'h53: ch = 8'h2E;
            7'h73: ch = 8'h5F;
            7'h7D: ch = 8'h7C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> hw/rtl/keyboard_scancode_translator.sv
// keyboard scancode translator: set-1 codes to characters, lock LED command queue
//
//  channel  ports                                   dir  handshake
//  input    s_valid s_ready s_opcode s_scancode     in   valid/ready
//  result   m_valid m_ready m_kind m_value          out  valid/ready
//  config   cfg_we cfg_wdata                        in   write enable only
//
// one word per cycle in each direction while m_ready stays high
// a word passes through the input register, then is translated into the result register
// all state updates for a word happen in the cycle it moves to the result register
// a stalled result holds the input register, which still takes one word
// aresetn clears control state, the queue storage is not cleared
module keyboard_scancode_translator #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_opcode,
    input  logic [7:0] s_scancode,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [7:0] m_value
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    logic [2:0]       initial_leds_reg;
    logic             in_valid_reg;
    logic             in_opcode_reg;
    logic [7:0]       in_code_reg;
    logic [1:0]       shift_reg, shift_next;
    logic [2:0]       leds_reg, leds_next;
    logic             awaiting_reg, awaiting_next;
    logic [7:0]       pending_reg, pending_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       queue_mem [QUEUE_DEPTH];
    logic [7:0]       head_byte_reg;

    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [7:0]       out_value_reg;

    logic             advance;
    logic             is_scan;
    logic [7:0]       ch_raw, ch;
    logic             caps, shifted;
    logic             push_req, push1_ok, push2_ok;
    logic [PTR_W-1:0] tail1;
    logic [CNT_W-1:0] cnt1, count_after;
    logic             awaiting_after;
    logic             resend;
    logic             pop;
    logic [7:0]       pop_byte;
    kst_pkg::result_t res;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        is_scan = (in_opcode_reg == kst_pkg::OP_SCAN);
        ch_raw  = 8'h00;
        if (is_scan && !in_code_reg[7]) begin
            ch_raw = (shift_reg == 2'b00) ? kst_pkg::rom_plain(in_code_reg[6:0])
                                          : kst_pkg::rom_shift(in_code_reg[6:0]);
        end
        caps    = |(leds_reg & kst_pkg::LED_CAPS);
        shifted = (shift_reg != 2'b00);
        ch      = ch_raw;
        if (ch_raw >= kst_pkg::CHAR_UPPER_A && ch_raw <= kst_pkg::CHAR_UPPER_Z
                && caps == shifted) begin
            ch = ch_raw + kst_pkg::CASE_OFFSET;
        end
    end

    always_comb begin
        shift_next = shift_reg;
        leds_next  = leds_reg;
        push_req   = 1'b0;
        if (!is_scan) begin
            leds_next = initial_leds_reg;
            push_req  = 1'b1;
        end else begin
            case (in_code_reg)
                kst_pkg::CODE_LSHIFT:   shift_next = shift_reg | 2'b01;
                kst_pkg::CODE_RSHIFT:   shift_next = shift_reg | 2'b10;
                kst_pkg::CODE_LSHIFT_R: shift_next = shift_reg & 2'b10;
                kst_pkg::CODE_RSHIFT_R: shift_next = shift_reg & 2'b01;
                kst_pkg::CODE_CAPS: begin
                    leds_next = leds_reg ^ kst_pkg::LED_CAPS;
                    push_req  = 1'b1;
                end
                kst_pkg::CODE_NUM: begin
                    leds_next = leds_reg ^ kst_pkg::LED_NUM;
                    push_req  = 1'b1;
                end
                kst_pkg::CODE_SCROLL: begin
                    leds_next = leds_reg ^ kst_pkg::LED_SCROLL;
                    push_req  = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // up to two pushes for a sync word or lock key, each while there is room: the led command, then the new led bits
    always_comb begin
        push1_ok    = push_req && (count_reg < DEPTH_C);
        cnt1        = count_reg + CNT_W'(push1_ok);
        tail1       = push1_ok ? ptr_inc(tail_reg) : tail_reg;
        push2_ok    = push_req && (cnt1 < DEPTH_C);
        count_after = cnt1 + CNT_W'(push2_ok);
        tail_next   = push2_ok ? ptr_inc(tail1) : tail1;

        awaiting_after = awaiting_reg && !(is_scan && in_code_reg == kst_pkg::CODE_ACK);
        resend = is_scan && (in_code_reg == kst_pkg::CODE_RESEND) && awaiting_reg;

        // an empty queue means the head is the led command written this word
        pop_byte = (count_reg == '0) ? kst_pkg::CMD_LED : head_byte_reg;

        pop           = 1'b0;
        awaiting_next = awaiting_after;
        pending_next  = pending_reg;
        head_next     = head_reg;
        res.valid     = 1'b0;
        res.kind      = kst_pkg::KIND_CHAR;
        res.value     = ch;
        if (ch != 8'h00) begin
            res.valid = 1'b1;
        end else if (resend) begin
            res.valid = 1'b1;
            res.kind  = kst_pkg::KIND_CMD;
            res.value = pending_reg;
        end else if (!awaiting_after && count_after != '0) begin
            pop           = 1'b1;
            res.valid     = 1'b1;
            res.kind      = kst_pkg::KIND_CMD;
            res.value     = pop_byte;
            pending_next  = pop_byte;
            awaiting_next = 1'b1;
            head_next     = ptr_inc(head_reg);
        end
        count_next = count_after - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_leds_reg <= 3'b000;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            shift_reg        <= 2'b00;
            leds_reg         <= 3'b000;
            awaiting_reg     <= 1'b0;
            pending_reg      <= 8'h00;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
        end else begin
            if (cfg_we) begin
                initial_leds_reg <= cfg_wdata;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= res.valid;
                shift_reg     <= shift_next;
                leds_reg      <= leds_next;
                awaiting_reg  <= awaiting_next;
                pending_reg   <= pending_next;
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                count_reg     <= count_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_opcode_reg <= s_opcode;
            in_code_reg   <= s_scancode;
        end
        if (advance) begin
            out_kind_reg  <= res.kind;
            out_value_reg <= res.value;
            if (push1_ok) begin
                queue_mem[tail_reg] <= kst_pkg::CMD_LED;
            end
            if (push2_ok) begin
                queue_mem[tail1] <= {5'b00000, leds_next};
            end
            // head byte for the next word, taking a byte written at the head now
            if (push1_ok && head_next == tail_reg) begin
                head_byte_reg <= kst_pkg::CMD_LED;
            end else if (push2_ok && head_next == tail1) begin
                head_byte_reg <= {5'b00000, leds_next};
            end else begin
                head_byte_reg <= queue_mem[head_next];
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_kind  = out_kind_reg;
    assign m_value = out_value_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("queue count above depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> head_reg == tail_reg)
        else $error("empty queue with head and tail apart");

    a_pop_sets_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && pop |=> awaiting_reg && m_valid && m_kind == kst_pkg::KIND_CMD)
        else $error("sent word without waiting for acknowledge");

    a_resend_value: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && resend && ch == 8'h00 |=> m_value == $past(pending_reg))
        else $error("resend word differs from pending word");

    a_no_pop_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && awaiting_after |-> !pop)
        else $error("pop while waiting for acknowledge");
`endif

endmodule

>>> bench/testbench.sv
// testbench for the keyboard scancode translator: directed table, random typing, led traffic
`timescale 1ns / 1ps

module testbench;

    localparam int QDEPTH = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    // layout tables, index 0 is the leftmost byte
    localparam logic [0:127][7:0] PLAIN_MAP = {
        128'h00003132_33343536_37383930_2D5E0800,
        128'h51574552_54595549_4F50405B_0A004153,
        128'h44464748_4A4B4C3B_3A00005D_5A584356,
        128'h424E4D2C_2E2F002A_00200000_00000000,
        128'h00000000_00000037_38392D34_35362B31,
        128'h3233302E_00000000_00000000_00000000,
        128'h00000000_00000000_00000000_00000000,
        128'h0000005C_00000000_00000000_005C0000
    };
    localparam logic [0:127][7:0] SHIFT_MAP = {
        128'h00002122_23242526_2728297E_3D7E0800,
        128'h51574552_54595549_4F50607B_0A004153,
        128'h44464748_4A4B4C2B_2A00007D_5A584356,
        128'h424E4D3C_3E3F002A_00200000_00000000,
        128'h00000000_00000037_38392D34_35362B31,
        128'h3233302E_00000000_00000000_00000000,
        128'h00000000_00000000_00000000_00000000,
        128'h0000005F_00000000_00000000_007C0000
    };

    typedef struct packed {
        logic       op;
        logic [7:0] code;
        logic       typed;
        logic       has;
        logic       kind;
        logic [7:0] value;
    } key_row_t;

    localparam int N_DIRECTED = 28;
    localparam key_row_t DIRECTED [N_DIRECTED] = '{
        '{kst_pkg::OP_SCAN, 8'h00, 1'b1, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, 8'h1E, 1'b1, 1'b1, kst_pkg::KIND_CHAR, 8'h61},
        '{kst_pkg::OP_SCAN, 8'h7F, 1'b1, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, 8'h7D, 1'b1, 1'b1, kst_pkg::KIND_CHAR, 8'h5C},
        '{kst_pkg::OP_SCAN, 8'hFF, 1'b1, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_ACK, 1'b1, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_RESEND, 1'b1, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_LSHIFT, 1'b1, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, 8'h1E, 1'b1, 1'b1, kst_pkg::KIND_CHAR, 8'h41},
        '{kst_pkg::OP_SCAN, 8'h02, 1'b1, 1'b1, kst_pkg::KIND_CHAR, 8'h21},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_RSHIFT, 1'b0, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_LSHIFT_R, 1'b0, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, 8'h7D, 1'b0, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_RSHIFT_R, 1'b0, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_CAPS, 1'b1, 1'b1, kst_pkg::KIND_CMD, kst_pkg::CMD_LED},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_RESEND, 1'b1, 1'b1, kst_pkg::KIND_CMD, kst_pkg::CMD_LED},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_ACK, 1'b1, 1'b1, kst_pkg::KIND_CMD, 8'h04},
        '{kst_pkg::OP_SCAN, 8'h1E, 1'b0, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_LSHIFT, 1'b0, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, 8'h1E, 1'b0, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_LSHIFT_R, 1'b0, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_ACK, 1'b1, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SYNC, 8'hFF, 1'b1, 1'b1, kst_pkg::KIND_CMD, kst_pkg::CMD_LED},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_ACK, 1'b1, 1'b1, kst_pkg::KIND_CMD, 8'h07},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_NUM, 1'b0, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_ACK, 1'b0, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_ACK, 1'b0, 1'b0, kst_pkg::KIND_CHAR, 8'h00},
        '{kst_pkg::OP_SCAN, kst_pkg::CODE_ACK, 1'b0, 1'b0, kst_pkg::KIND_CHAR, 8'h00}
    };

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [2:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic       s_opcode;
    logic [7:0] s_scancode;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_kind;
    logic [7:0] m_value;

    // predicted keyboard state
    logic [1:0] held_shift;
    logic [2:0] leds;
    logic       ack_wait;
    logic [7:0] last_sent;
    logic [2:0] start_leds;
    logic [7:0] led_cmds [$];
    logic [8:0] expected_words [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  words_sent;
    int  quiet_cycles = 0;
    bit  failed = 1'b0;

    keyboard_scancode_translator #(
        .QUEUE_DEPTH (QDEPTH)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_scancode (s_scancode),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_value    (m_value)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void queue_led_byte(input logic [7:0] b);
        if (led_cmds.size() < QDEPTH) begin
            led_cmds.push_back(b);
        end
    endfunction

    function automatic void toggle_lock(input logic [2:0] mask);
        leds = leds ^ mask;
        queue_led_byte(kst_pkg::CMD_LED);
        queue_led_byte({5'b0, leds});
    endfunction

    function automatic void translate_key(input logic op, input logic [7:0] code,
            output logic has, output logic kind, output logic [7:0] value);
        logic [7:0] ch;
        logic       repeat_last;
        ch = 8'h00;
        repeat_last = 1'b0;
        has = 1'b0;
        kind = kst_pkg::KIND_CHAR;
        value = 8'h00;
        if (op == kst_pkg::OP_SYNC) begin
            leds = start_leds;
            queue_led_byte(kst_pkg::CMD_LED);
            queue_led_byte({5'b0, leds});
        end else begin
            if (!code[7]) begin
                ch = (held_shift == 2'b00) ? PLAIN_MAP[code[6:0]] : SHIFT_MAP[code[6:0]];
                // fold to lower case unless exactly one of caps and shift
                if (ch >= kst_pkg::CHAR_UPPER_A && ch <= kst_pkg::CHAR_UPPER_Z &&
                        (leds[2] == (held_shift != 2'b00))) begin
                    ch = ch + kst_pkg::CASE_OFFSET;
                end
            end
            case (code)
                kst_pkg::CODE_LSHIFT:   held_shift[0] = 1'b1;
                kst_pkg::CODE_RSHIFT:   held_shift[1] = 1'b1;
                kst_pkg::CODE_LSHIFT_R: held_shift[0] = 1'b0;
                kst_pkg::CODE_RSHIFT_R: held_shift[1] = 1'b0;
                kst_pkg::CODE_CAPS:     toggle_lock(kst_pkg::LED_CAPS);
                kst_pkg::CODE_NUM:      toggle_lock(kst_pkg::LED_NUM);
                kst_pkg::CODE_SCROLL:   toggle_lock(kst_pkg::LED_SCROLL);
                kst_pkg::CODE_ACK:      ack_wait = 1'b0;
                kst_pkg::CODE_RESEND:   repeat_last = ack_wait;
                default: ;
            endcase
        end
        if (ch != 8'h00) begin
            has = 1'b1;
            value = ch;
        end else if (repeat_last) begin
            has = 1'b1;
            kind = kst_pkg::KIND_CMD;
            value = last_sent;
        end else if (!ack_wait && led_cmds.size() != 0) begin
            last_sent = led_cmds.pop_front();
            ack_wait = 1'b1;
            has = 1'b1;
            kind = kst_pkg::KIND_CMD;
            value = last_sent;
        end
    endfunction

    task automatic send_word(input key_row_t row);
        logic       has;
        logic       kind;
        logic [7:0] value;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_opcode <= row.op;
        s_scancode <= row.code;
        do @(posedge aclk); while (!s_ready);
        translate_key(row.op, row.code, has, kind, value);
        if (row.typed) begin
            has = row.has;
            kind = row.kind;
            value = row.value;
        end
        if (has) begin
            expected_words.push_back({kind, value});
        end
        words_sent++;
    endtask

    task automatic send_key(input logic op, input logic [7:0] code);
        key_row_t row;
        row = '0;
        row.op = op;
        row.code = code;
        send_word(row);
    endtask

    task automatic wait_for_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_start_leds(input logic [2:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        start_leds = v;
    endtask

    function automatic logic [7:0] pick_lock_key();
        case ($urandom_range(2))
            0: return kst_pkg::CODE_CAPS;
            1: return kst_pkg::CODE_NUM;
            default: return kst_pkg::CODE_SCROLL;
        endcase
    endfunction

    task automatic type_randomly(input int count);
        int stop_at;
        int r;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 3) begin
                // burst of lock keys with no acks, can overflow the led queue
                repeat ($urandom_range(16, 22)) send_key(kst_pkg::OP_SCAN, pick_lock_key());
            end else if (r < 33) begin
                send_key(kst_pkg::OP_SCAN, 8'($urandom_range(127)));
            end else if (r < 43) begin
                case ($urandom_range(3))
                    0: send_key(kst_pkg::OP_SCAN, kst_pkg::CODE_LSHIFT);
                    1: send_key(kst_pkg::OP_SCAN, kst_pkg::CODE_RSHIFT);
                    2: send_key(kst_pkg::OP_SCAN, kst_pkg::CODE_LSHIFT_R);
                    default: send_key(kst_pkg::OP_SCAN, kst_pkg::CODE_RSHIFT_R);
                endcase
            end else if (r < 50) begin
                send_key(kst_pkg::OP_SCAN, pick_lock_key());
            end else if (r < 72) begin
                send_key(kst_pkg::OP_SCAN, kst_pkg::CODE_ACK);
            end else if (r < 78) begin
                send_key(kst_pkg::OP_SCAN, kst_pkg::CODE_RESEND);
            end else if (r < 83) begin
                send_key(kst_pkg::OP_SYNC, 8'($urandom_range(255)));
            end else if (r < 93) begin
                send_key(1'($urandom_range(1)), 8'($urandom_range(255)));
            end else begin
                send_key(kst_pkg::OP_SCAN, 8'($urandom_range(255, 128)));
            end
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : check_words
        logic [8:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: kind %0d value %02h", m_kind, m_value);
                failed = 1'b1;
            end else begin
                want = expected_words.pop_front();
                if (m_kind !== want[8]) begin
                    $error("kind: expected %0d, got %0d", want[8], m_kind);
                    failed = 1'b1;
                end
                if (m_value !== want[7:0]) begin
                    $error("value: expected %02h, got %02h", want[7:0], m_value);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 3'b000;
        s_valid = 1'b0;
        s_opcode = kst_pkg::OP_SCAN;
        s_scancode = 8'h00;
        held_shift = 2'b00;
        leds = 3'b000;
        ack_wait = 1'b0;
        last_sent = 8'h00;
        start_leds = 3'b000;
        words_sent = 0;
        send_idle_pct = 29;
        recv_idle_pct = 69;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_start_leds(3'b111);
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_word(DIRECTED[i]);
        end
        wait_for_quiet();

        write_start_leds(3'b000);
        type_randomly(140);
        wait_for_quiet();

        send_idle_pct = 69;
        recv_idle_pct = 29;
        write_start_leds(3'($urandom_range(6, 1)));
        type_randomly(140);
        wait_for_quiet();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_start_leds(3'($urandom_range(7)));
        type_randomly(140);
        wait_for_quiet();

        if (!failed) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
